/* hdl/frame_deframer_with_liveness_top_macros.svh */
// Assertion macros for the frame deframer with link liveness checks.
`ifndef FRAME_DEFRAMER_WITH_LIVENESS_TOP_MACROS_SVH
`define FRAME_DEFRAMER_WITH_LIVENESS_TOP_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define FDL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FDL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`else

`define FDL_ASSERT_SAME(label, ante, cons)
`define FDL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/fdl_pkg.sv */
// Types and constants shared by the frame deframer with link liveness checks.
package fdl_pkg;

  // Header layout.
  localparam int HEADER_BYTES = 12;
  localparam int HDR_COUNT_W  = 4;

  // Request codes.
  localparam logic [1:0] REQ_RX   = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_TX   = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Link status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_PROTOCOL = 2'd1;
  localparam logic [1:0] STATUS_IDLE     = 2'd2;
  localparam logic [1:0] STATUS_STALL    = 2'd3;

  // Frame kinds.
  localparam logic [15:0] KIND_APP  = 16'd0;
  localparam logic [15:0] KIND_PING = 16'd1;
  localparam logic [15:0] KIND_PONG = 16'd2;

  // Configuration register map.
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_IDENTIFIER = 3'd0;
  localparam logic [2:0] REG_VERSION    = 3'd1;
  localparam logic [2:0] REG_MAX_PAYLOAD = 3'd2;
  localparam logic [2:0] REG_IDLE       = 3'd3;
  localparam logic [2:0] REG_LIVENESS   = 3'd4;
  localparam logic [2:0] REG_PROGRESS   = 3'd5;

  // Reset values of the registers.
  localparam logic [31:0] RST_IDENTIFIER  = 32'd0;
  localparam logic [15:0] RST_VERSION     = 16'd0;
  localparam logic [31:0] RST_MAX_PAYLOAD = 32'd65536;
  localparam logic [15:0] RST_IDLE        = 16'd300;
  localparam logic [15:0] RST_LIVENESS    = 16'd100;
  localparam logic [15:0] RST_PROGRESS    = 16'd50;

  // One input item.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       send_pong;
    logic       send_ping;
    logic [1:0] link_status;
  } out_item_t;

endpackage

/* hdl/frame_deframer_with_liveness_top.sv */
// Receive-side frame deframer with idle, stall and liveness supervision.
`include "frame_deframer_with_liveness_top_macros.svh"

// The block takes one item per clock cycle, unless a waiting result holds it,
// and gives one result item for each. An accepted item is held in an input
// register; once the result register is free, the whole header, payload and
// tick update for it is done combinationally on its way into the result
// register, which raises result_valid. That state update (byte count, payload
// count, tick counters and fault code) sets the rate. While a result waits,
// one more item can still be taken into the input register; after that, a new
// item is taken only in a cycle in which the waiting result is taken.
// Configuration registers are written over the APB-style port at byte address
// 4*i and must only change while the block holds no item. A fault is sticky
// until reset; after it every item returns only the fault code.
module frame_deframer_with_liveness_top #(
  parameter int TICK_COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // Input items
  input  logic                    item_valid,
  output logic                    item_ready,
  input  fdl_pkg::in_item_t       item,
  // Result items
  output logic                    result_valid,
  input  logic                    result_ready,
  output fdl_pkg::out_item_t      result,
  // Configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [fdl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import fdl_pkg::*;

  // Comparison width covering both the tick counters and the 16-bit limits.
  localparam int CW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
  localparam int TW = TICK_COUNTER_BITS;

  // Configuration registers.
  logic [31:0] frame_identifier;
  logic [15:0] frame_version;
  logic [31:0] max_payload;
  logic [15:0] idle_limit;
  logic [15:0] liveness_limit;
  logic [15:0] progress_limit;

  logic [2:0] reg_index;
  logic       cfg_write;

  // Input and result registers.
  logic      in_valid;
  in_item_t  in_q;
  out_item_t res_next;
  logic      fire;

  // Deframer state.
  logic [HDR_COUNT_W-1:0] header_count, header_count_next;
  logic [8*(HEADER_BYTES-1)-1:0] header_shift, header_shift_next;
  logic [31:0]  payload_left, payload_left_next;
  logic [31:0]  frame_len, frame_len_next;
  logic         in_payload, in_payload_next;
  logic [TW-1:0] rx_quiet_ticks, rx_quiet_ticks_next;
  logic [TW-1:0] tx_quiet_ticks, tx_quiet_ticks_next;
  logic [TW-1:0] stall_ticks, stall_ticks_next;
  logic [1:0]   fault_code, fault_code_next;

  // Header fields as seen on the byte that completes it.
  logic [8*HEADER_BYTES-1:0] header_full;
  logic [31:0] hdr_identifier;
  logic [15:0] hdr_version;
  logic [15:0] hdr_kind;
  logic [31:0] hdr_len;
  logic        hdr_bad;

  // Saturated tick counts for a tick item.
  logic [TW-1:0] rx_up, tx_up, stall_up;
  logic          partial;

  // APB register access.
  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_identifier <= RST_IDENTIFIER;
      frame_version    <= RST_VERSION;
      max_payload      <= RST_MAX_PAYLOAD;
      idle_limit       <= RST_IDLE;
      liveness_limit   <= RST_LIVENESS;
      progress_limit   <= RST_PROGRESS;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_IDENTIFIER:  frame_identifier <= pwdata;
        REG_VERSION:     frame_version    <= pwdata[15:0];
        REG_MAX_PAYLOAD: max_payload      <= pwdata;
        REG_IDLE:        idle_limit       <= pwdata[15:0];
        REG_LIVENESS:    liveness_limit   <= pwdata[15:0];
        REG_PROGRESS:    progress_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_IDENTIFIER:  prdata = frame_identifier;
      REG_VERSION:     prdata = {16'd0, frame_version};
      REG_MAX_PAYLOAD: prdata = max_payload;
      REG_IDLE:        prdata = {16'd0, idle_limit};
      REG_LIVENESS:    prdata = {16'd0, liveness_limit};
      REG_PROGRESS:    prdata = {16'd0, progress_limit};
      default:         prdata = 32'd0;
    endcase
  end

  // Handshake: the held item moves on whenever the result register is free or being emptied.
  assign fire       = in_valid && (!result_valid || result_ready);
  assign item_ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_ready) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  // Header decode: eleven stored bytes and the byte now arriving.
  assign header_full    = {header_shift, in_q.rx_byte};
  assign hdr_identifier = header_full[95:64];
  assign hdr_version    = header_full[63:48];
  assign hdr_kind       = header_full[47:32];
  assign hdr_len        = header_full[31:0];
  assign hdr_bad = (hdr_identifier != frame_identifier) || (hdr_version != frame_version)
                   || (hdr_kind > KIND_PONG) || (hdr_len > max_payload)
                   || ((hdr_kind != KIND_APP) && (hdr_len != 32'd0));

  // Saturating tick counters.
  assign rx_up    = (&rx_quiet_ticks) ? rx_quiet_ticks : rx_quiet_ticks + 1'b1;
  assign tx_up    = (&tx_quiet_ticks) ? tx_quiet_ticks : tx_quiet_ticks + 1'b1;
  assign stall_up = (&stall_ticks)    ? stall_ticks    : stall_ticks + 1'b1;
  assign partial  = in_payload ? (payload_left != frame_len) : (header_count != '0);

  // Next state and result for the held item.
  always_comb begin
    header_count_next   = header_count;
    header_shift_next   = header_shift;
    payload_left_next   = payload_left;
    frame_len_next      = frame_len;
    in_payload_next     = in_payload;
    rx_quiet_ticks_next = rx_quiet_ticks;
    tx_quiet_ticks_next = tx_quiet_ticks;
    stall_ticks_next    = stall_ticks;
    fault_code_next     = fault_code;
    res_next            = '0;

    if (fault_code == STATUS_OK) begin
      unique case (in_q.req_type)
        REQ_RX: begin
          rx_quiet_ticks_next = '0;
          stall_ticks_next    = '0;
          if (in_payload) begin
            // Payload byte is passed through.
            res_next.payload_valid = 1'b1;
            res_next.payload_byte  = in_q.rx_byte;
            payload_left_next      = payload_left - 32'd1;
            if (payload_left == 32'd1) begin
              res_next.frame_end = 1'b1;
              in_payload_next    = 1'b0;
              header_count_next  = '0;
            end
          end else begin
            // Header byte is gathered; the twelfth one is checked.
            header_shift_next = header_full[8*(HEADER_BYTES-1)-1:0];
            if (header_count == HDR_COUNT_W'(HEADER_BYTES - 1)) begin
              header_count_next = '0;
              if (hdr_bad) begin
                fault_code_next = STATUS_PROTOCOL;
              end else if (hdr_kind == KIND_APP) begin
                if (hdr_len == 32'd0) begin
                  res_next.frame_end = 1'b1;
                end else begin
                  in_payload_next   = 1'b1;
                  payload_left_next = hdr_len;
                  frame_len_next    = hdr_len;
                end
              end else if (hdr_kind == KIND_PING) begin
                res_next.send_pong = 1'b1;
              end
            end else begin
              header_count_next = header_count + 1'b1;
            end
          end
        end
        REQ_TICK: begin
          rx_quiet_ticks_next = rx_up;
          tx_quiet_ticks_next = tx_up;
          stall_ticks_next    = stall_up;
          if (CW'(rx_up) >= CW'(idle_limit)) begin
            fault_code_next = STATUS_IDLE;
          end else if (partial && (CW'(stall_up) >= CW'(progress_limit))) begin
            // A stall withdraws the ping of the same tick.
            fault_code_next = STATUS_STALL;
          end else begin
            res_next.send_ping = (CW'(rx_up) >= CW'(liveness_limit))
                                 && (CW'(tx_up) >= CW'(liveness_limit));
          end
        end
        REQ_TX: begin
          tx_quiet_ticks_next = '0;
        end
        REQ_NONE: ;
        default: ;
      endcase
    end
    res_next.link_status = fault_code_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count   <= '0;
      payload_left   <= '0;
      in_payload     <= 1'b0;
      rx_quiet_ticks <= '0;
      tx_quiet_ticks <= '0;
      stall_ticks    <= '0;
      fault_code     <= STATUS_OK;
    end else if (fire) begin
      header_count   <= header_count_next;
      payload_left   <= payload_left_next;
      in_payload     <= in_payload_next;
      rx_quiet_ticks <= rx_quiet_ticks_next;
      tx_quiet_ticks <= tx_quiet_ticks_next;
      stall_ticks    <= stall_ticks_next;
      fault_code     <= fault_code_next;
    end
  end

  // Header bytes and frame length need no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      header_shift <= header_shift_next;
      frame_len    <= frame_len_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

  // Checks on the deframer state.
  `FDL_ASSERT_NEXT(a_fault_sticky, fault_code != STATUS_OK, $stable(fault_code))
  `FDL_ASSERT_SAME(a_count_range, 1'b1, header_count < HDR_COUNT_W'(HEADER_BYTES))
  `FDL_ASSERT_SAME(a_payload_left, in_payload, payload_left != 32'd0)
  `FDL_ASSERT_SAME(a_payload_no_header, in_payload, header_count == '0)
  `FDL_ASSERT_SAME(a_payload_ok, result_valid && result.payload_valid,
                   result.link_status == STATUS_OK)

endmodule

/* tb/deframer_check_pkg.sv */
// Expected-behaviour tracker for the frame deframer with link liveness checks.
package deframer_check_pkg;

  import fdl_pkg::*;

  localparam int TICK_BITS = 16;

  class deframer_tracker;

    // Register copies, at their reset values until written.
    logic [31:0] cfg_ident    = RST_IDENTIFIER;
    logic [15:0] cfg_ver      = RST_VERSION;
    logic [31:0] cfg_max_len  = RST_MAX_PAYLOAD;
    logic [15:0] cfg_idle_lim = RST_IDLE;
    logic [15:0] cfg_live_lim = RST_LIVENESS;
    logic [15:0] cfg_prog_lim = RST_PROGRESS;

    // Link state as the block should hold it.
    logic [7:0]           hdr_bytes [HEADER_BYTES];
    int                   hdr_fill    = 0;
    logic [31:0]          bytes_to_go = '0;
    bit                   mid_payload = 1'b0;
    logic [TICK_BITS-1:0] rx_idle     = '0;
    logic [TICK_BITS-1:0] tx_idle     = '0;
    logic [TICK_BITS-1:0] stall_age   = '0;
    logic [1:0]           fault       = STATUS_OK;

    // Result items still owed by the block, oldest first.
    out_item_t pending_outputs [$];

    int failures;
    int payload_bytes;
    int frame_ends;
    int pongs;
    int pings;

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_IDENTIFIER:  cfg_ident    = val;
        REG_VERSION:     cfg_ver      = val[15:0];
        REG_MAX_PAYLOAD: cfg_max_len  = val;
        REG_IDLE:        cfg_idle_lim = val[15:0];
        REG_LIVENESS:    cfg_live_lim = val[15:0];
        REG_PROGRESS:    cfg_prog_lim = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [TICK_BITS-1:0] bump(logic [TICK_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function logic [31:0] header_len();
      return {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
    endfunction

    // A frame counts as partly received once a header byte or a payload byte has come in.
    function bit mid_frame();
      return mid_payload ? (bytes_to_go != header_len()) : (hdr_fill != 0);
    endfunction

    // Would a tick taken now raise the idle or the stall fault?
    function bit tick_faults();
      if (fault != STATUS_OK) return 1'b0;
      if (bump(rx_idle) >= cfg_idle_lim) return 1'b1;
      return mid_frame() && (bump(stall_age) >= cfg_prog_lim);
    endfunction

    // Advance the link state by one accepted item and queue the result it owes.
    function void absorb_event(in_item_t ev);
      out_item_t   r;
      logic [15:0] kind;
      logic [31:0] len;
      r = '0;
      if (fault == STATUS_OK) begin
        case (ev.req_type)
          REQ_RX: begin
            rx_idle   = '0;
            stall_age = '0;
            if (mid_payload) begin
              r.payload_valid = 1'b1;
              r.payload_byte  = ev.rx_byte;
              bytes_to_go     = bytes_to_go - 1;
              if (bytes_to_go == 0) begin
                r.frame_end = 1'b1;
                mid_payload = 1'b0;
                hdr_fill    = 0;
              end
            end else begin
              hdr_bytes[hdr_fill] = ev.rx_byte;
              hdr_fill++;
              if (hdr_fill == HEADER_BYTES) begin
                hdr_fill = 0;
                kind = {hdr_bytes[6], hdr_bytes[7]};
                len  = header_len();
                if ({hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != cfg_ident
                    || {hdr_bytes[4], hdr_bytes[5]} != cfg_ver || kind > KIND_PONG
                    || len > cfg_max_len || (kind != KIND_APP && len != 0)) begin
                  fault = STATUS_PROTOCOL;
                end else if (kind == KIND_APP) begin
                  if (len == 0) begin
                    r.frame_end = 1'b1;
                  end else begin
                    mid_payload = 1'b1;
                    bytes_to_go = len;
                  end
                end else if (kind == KIND_PING) begin
                  r.send_pong = 1'b1;
                end
              end
            end
          end
          REQ_TICK: begin
            rx_idle   = bump(rx_idle);
            tx_idle   = bump(tx_idle);
            stall_age = bump(stall_age);
            if (rx_idle >= cfg_idle_lim) begin
              fault = STATUS_IDLE;
            end else begin
              r.send_ping = (rx_idle >= cfg_live_lim) && (tx_idle >= cfg_live_lim);
              // A stall overrides any ping asked for on the same tick.
              if (mid_frame() && stall_age >= cfg_prog_lim) begin
                fault       = STATUS_STALL;
                r.send_ping = 1'b0;
              end
            end
          end
          REQ_TX: tx_idle = '0;
          default: ;
        endcase
      end
      r.link_status = fault;
      payload_bytes += r.payload_valid;
      frame_ends    += r.frame_end;
      pongs         += r.send_pong;
      pings         += r.send_ping;
      pending_outputs = {pending_outputs, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_outputs.size() == 0) begin
        $error("result item %h arrived with none outstanding", got);
        failures++;
        return;
      end
      want = pending_outputs[0];
      pending_outputs.delete(0);
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("send_pong", want.send_pong, got.send_pong);
      compare_field("send_ping", want.send_ping, got.send_ping);
      compare_field("link_status", want.link_status, got.link_status);
    endfunction

  endclass

endpackage

/* tb/frame_deframer_with_liveness_top_test.sv */
// Self-checking testbench for the frame deframer with link liveness checks.
module frame_deframer_with_liveness_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import fdl_pkg::*;
  import deframer_check_pkg::*;

  // Cycles without any accepted item or taken result before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  in_item_t          item         = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  out_item_t         result;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  deframer_tracker tracker = new();

  int send_gap_pct = 0;
  int take_gap_pct = 0;
  int events_sent  = 0;
  int quiet_cycles = 0;
  int closing_case = 0;

  frame_deframer_with_liveness_top #(.TICK_COUNTER_BITS(TICK_BITS)) dut (
    .clk, .rst,
    .item_valid, .item_ready, .item,
    .result_valid, .result_ready, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: check every accepted item, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) tracker.check_result(result);
      result_ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Watchdog on forward progress of either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("frame_deframer_with_liveness_top: mismatch");
        $finish;
      end
    end
  end

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] ident, logic [31:0] ver, logic [31:0] max_len,
                           logic [31:0] idle, logic [31:0] live, logic [31:0] prog);
    write_reg(REG_IDENTIFIER, ident);
    write_reg(REG_VERSION, ver);
    write_reg(REG_MAX_PAYLOAD, max_len);
    write_reg(REG_IDLE, idle);
    write_reg(REG_LIVENESS, live);
    write_reg(REG_PROGRESS, prog);
  endtask

  // Offer one item, with a random number of empty cycles first, and hold it until taken.
  task automatic send_event(logic [1:0] code, logic [7:0] data);
    in_item_t ev;
    ev.req_type = code;
    ev.rx_byte  = data;
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= ev;
    do @(posedge clk); while (!item_ready);
    if (code != REQ_NONE && tracker.fault == STATUS_OK) events_sent++;
    tracker.absorb_event(ev);
  endtask

  // Lower valid and wait until every owed result item has come back.
  task automatic settle_outputs();
    item_valid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A stray event between received bytes; ticks only where they cannot fault the link.
  task automatic send_noise();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0 && !tracker.tick_faults()) send_event(REQ_TICK, 8'($urandom));
    else if (pick == 2) send_event(REQ_NONE, 8'($urandom));
    else send_event(REQ_TX, 8'($urandom));
  endtask

  task automatic tick_run(int n);
    repeat (n) begin
      if (tracker.tick_faults()) break;
      send_event(REQ_TICK, 8'($urandom));
    end
  endtask

  // Send the first nbytes of a header, most significant byte first.
  task automatic send_header(logic [95:0] hdr, int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < 12) send_noise();
      send_event(REQ_RX, hdr[95-8*i -: 8]);
    end
  endtask

  task automatic send_frame(logic [15:0] kind, logic [31:0] len);
    send_header({tracker.cfg_ident, tracker.cfg_ver, kind, len}, HEADER_BYTES);
    if (kind == KIND_APP) begin
      for (int unsigned n = 0; n < len; n++) begin
        if ($urandom_range(99) < 12) send_noise();
        send_event(REQ_RX, 8'($urandom));
      end
    end
  endtask

  // Mostly well-formed frames with random content, the rest quiet spells and stray events.
  task automatic random_traffic(int budget);
    int          start;
    int          pick;
    logic [15:0] kind;
    logic [31:0] len;
    start = events_sent;
    while (events_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        pick = $urandom_range(99);
        kind = (pick < 70) ? KIND_APP : (pick < 88) ? KIND_PING : KIND_PONG;
        len  = 0;
        if (kind == KIND_APP) begin
          pick = $urandom_range(99);
          if (pick >= 93) len = $urandom_range(9, 120);
          else if (pick >= 15) len = $urandom_range(1, 8);
          if (len > tracker.cfg_max_len) len = tracker.cfg_max_len;
        end
        send_frame(kind, len);
      end else if (pick < 80) begin
        tick_run($urandom_range(1, (tracker.cfg_live_lim > 30) ? 30 : tracker.cfg_live_lim + 2));
      end else begin
        send_noise();
      end
    end
  endtask

  // End the run on one sticky fault, then show that the link stays frozen.
  task automatic close_with_fault();
    logic [31:0] ident;
    logic [15:0] ver;
    logic [15:0] kind;
    logic [31:0] len;
    ident = tracker.cfg_ident;
    ver   = tracker.cfg_ver;
    kind  = KIND_APP;
    len   = 0;
    closing_case = $urandom_range(7);
    case (closing_case)
      5: begin
        // Stall inside a header or inside a payload.
        if ($urandom_range(1)) begin
          send_header({ident, ver, kind, len}, $urandom_range(1, HEADER_BYTES - 1));
        end else begin
          len = $urandom_range(2, tracker.cfg_max_len);
          send_header({ident, ver, kind, len}, HEADER_BYTES);
          send_event(REQ_RX, 8'($urandom));
        end
        send_event(REQ_TICK, 8'($urandom));
      end
      6: begin
        while (tracker.fault == STATUS_OK) send_event(REQ_TICK, 8'($urandom));
      end
      7: begin
        // A zero idle limit faults on the very first tick.
        write_reg(REG_IDLE, 32'd0);
        send_event(REQ_TICK, 8'($urandom));
      end
      default: begin
        // Header violations: identifier, version, kind, length limit, control length.
        case (closing_case)
          0: ident = ident ^ ($urandom() | 32'd1);
          1: ver = ver ^ (16'($urandom()) | 16'd1);
          2: kind = 16'($urandom_range(3, 16'hFFFF));
          3: len = tracker.cfg_max_len + $urandom_range(1, 1000);
          default: begin
            kind = $urandom_range(1) ? KIND_PING : KIND_PONG;
            len  = $urandom_range(1, tracker.cfg_max_len);
          end
        endcase
        send_header({ident, ver, kind, len}, HEADER_BYTES);
      end
    endcase
    repeat (24) send_event(2'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First setting: all-ones identifier and version, widest length, longest idle limit.
    write_all(32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF,
              $urandom_range(2, 6), $urandom_range(2, 10));
    send_gap_pct = 37;
    take_gap_pct = 46;

    // Directed opening: stray events, a ping frame, then a quiet spell long enough to ping.
    send_event(REQ_NONE, 8'hFF);
    send_event(REQ_TX, 8'h00);
    send_event(REQ_TICK, 8'hA5);
    send_frame(KIND_PING, 32'd0);
    tick_run(tracker.cfg_live_lim + 1);
    random_traffic(450);
    settle_outputs();

    // Second setting: zero identifier, version and length; any tick would time out.
    write_all(32'd0, 32'd0, 32'd0, 32'd1, 32'hFFFF, 32'hFFFF);
    send_gap_pct = 46;
    take_gap_pct = 37;
    random_traffic(450);
    settle_outputs();

    // Third setting: random header fields, tightest liveness and progress limits, no idling.
    write_all($urandom(), $urandom_range(16'hFFFF), $urandom_range(2, 64),
              $urandom_range(8, 60), 32'd1, 32'd1);
    send_gap_pct = 0;
    take_gap_pct = 0;
    random_traffic(450);
    settle_outputs();

    close_with_fault();
    settle_outputs();

    $display("Covered %0d link events in three settings: %0d payload bytes, %0d frame ends,",
             events_sent, tracker.payload_bytes, tracker.frame_ends);
    $display("%0d pong and %0d ping requests, closing on fault case %0d with link status %0d.",
             tracker.pongs, tracker.pings, closing_case, tracker.fault);
    if (tracker.failures == 0 && tracker.pending_outputs.size() == 0) begin
      $display("frame_deframer_with_liveness_top: match");
    end else begin
      $display("frame_deframer_with_liveness_top: mismatch");
    end
    $finish;
  end

endmodule
